FILE: design/sk2u_pkg.sv
// ----------------------------------------------------------------------------
// sk2u_pkg: shared types and constants
// Byte codes, kana range limits and the command word passed front to back.
// ----------------------------------------------------------------------------
package sk2u_pkg;

  localparam logic [7:0] BYTE_ZERO     = 8'h00;
  localparam logic [7:0] BYTE_QUESTION = 8'h3F;
  localparam logic [7:0] BYTE_UNDER    = 8'h5F;
  localparam logic [7:0] LEAD_LOW      = 8'h80;
  localparam logic [7:0] HALF_FIRST    = 8'hA0;
  localparam logic [7:0] HALF_LAST     = 8'hDF;

  localparam logic [7:0] UTF8_LEAD3    = 8'hE0;
  localparam logic [7:0] UTF8_CONT     = 8'h80;

  // hiragana and the two katakana ranges
  localparam logic [15:0] HIRA_FIRST  = 16'h829F;
  localparam logic [15:0] HIRA_LAST   = 16'h82F1;
  localparam logic [15:0] HIRA_BASE   = 16'h3041;
  localparam logic [15:0] KATA1_FIRST = 16'h8340;
  localparam logic [15:0] KATA1_LAST  = 16'h837E;
  localparam logic [15:0] KATA1_BASE  = 16'h30A1;
  localparam logic [15:0] KATA2_FIRST = 16'h8380;
  localparam logic [15:0] KATA2_LAST  = 16'h8396;
  localparam logic [15:0] KATA2_BASE  = 16'h30E0;

  // code to code point offsets, modulo 2^16
  localparam logic [15:0] HIRA_OFS  = 16'(HIRA_BASE - HIRA_FIRST);
  localparam logic [15:0] KATA1_OFS = 16'(KATA1_BASE - KATA1_FIRST);
  localparam logic [15:0] KATA2_OFS = 16'(KATA2_BASE - KATA2_FIRST);

  localparam int unsigned MAX_BYTES = 4;
  localparam int unsigned IDX_W     = 2;

  // one classified input: up to four bytes to send
  typedef struct packed {
    logic [IDX_W-1:0]               last_idx;  // index of final byte
    logic                           term;      // final byte is the terminator
    logic [MAX_BYTES-1:0][7:0]      bytes;
  } cmd_t;

endpackage

FILE: design/sjis_kana_to_utf8_stream.sv
// an accepted word reaches the output via the command queue and the output register
// throughput: one input word per cycle while the command queue has room
// output runs one word per cycle while out_tready is high, 0 to 4 words per input
// sustained rate is set by the serializer, which sends each kana as three words
// reset clears lead, skip, queue and output state; no clearing pass
// ----------------------------------------------------------------------------
// sjis_kana_to_utf8_stream: Shift-JIS kana to UTF-8 byte stream converter
// Classifier front, command queue and serializer back.
// ----------------------------------------------------------------------------
module sjis_kana_to_utf8_stream #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // end_of_string
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // last_of_run
  output logic       out_tuser   // [0] end_of_text
);

  logic           q_full;
  logic           q_empty;
  logic           push;
  logic           pop;
  sk2u_pkg::cmd_t push_cmd;
  sk2u_pkg::cmd_t head;

  sk2u_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata),
    .in_eos   (in_tlast),
    .q_full   (q_full),
    .in_ready (in_tready),
    .push     (push),
    .push_cmd (push_cmd)
  );

  sk2u_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  sk2u_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (!q_empty),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: design/sk2u_front.sv
// ----------------------------------------------------------------------------
// sk2u_front: input classifier
// Takes one Shift-JIS byte per accepted word, tracks lead and skip state and,
// when the byte gives output, produces a command listing the UTF-8 bytes to send.
// ----------------------------------------------------------------------------
module sk2u_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  input  logic          in_eos,
  input  logic          q_full,
  output logic          in_ready,
  output logic          push,
  output sk2u_pkg::cmd_t push_cmd
);

  logic       lead_pending_r, lead_pending_nxt;
  logic [7:0] lead_value_r,   lead_value_nxt;
  logic       skipping_r,     skipping_nxt;
  logic       accept;
  logic       has_out;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && has_out;

  always_comb begin
    logic [15:0]               code;
    logic [15:0]               uni;
    logic                      hit;
    logic [sk2u_pkg::IDX_W-1:0] n;
    logic [sk2u_pkg::MAX_BYTES-1:0][7:0] b;
    code = {lead_value_r, in_byte};
    hit  = 1'b1;
    priority if (code >= sk2u_pkg::HIRA_FIRST && code <= sk2u_pkg::HIRA_LAST) begin
      uni = code + sk2u_pkg::HIRA_OFS;
    end else if (code >= sk2u_pkg::KATA1_FIRST && code <= sk2u_pkg::KATA1_LAST) begin
      uni = code + sk2u_pkg::KATA1_OFS;
    end else if (code >= sk2u_pkg::KATA2_FIRST && code <= sk2u_pkg::KATA2_LAST) begin
      uni = code + sk2u_pkg::KATA2_OFS;
    end else begin
      uni = 16'h0000;
      hit = 1'b0;
    end

    lead_pending_nxt = lead_pending_r;
    lead_value_nxt   = lead_value_r;
    skipping_nxt     = skipping_r;
    has_out          = 1'b1;
    b                = '0;
    n                = '0;

    if (skipping_r) begin
      has_out = 1'b0;
      if (in_eos) skipping_nxt = 1'b0;
    end else if (in_byte == sk2u_pkg::BYTE_ZERO) begin
      lead_pending_nxt = 1'b0;
      skipping_nxt     = !in_eos;
      if (lead_pending_r) begin
        b[0] = sk2u_pkg::BYTE_QUESTION;
        b[1] = sk2u_pkg::BYTE_ZERO;
        n    = 2'd1;
      end else begin
        b[0] = sk2u_pkg::BYTE_ZERO;
        n    = 2'd0;
      end
    end else begin
      if (lead_pending_r) begin
        lead_pending_nxt = 1'b0;
        if (hit) begin
          b[0] = sk2u_pkg::UTF8_LEAD3 | {4'h0, uni[15:12]};
          b[1] = sk2u_pkg::UTF8_CONT | {2'b00, uni[11:6]};
          b[2] = sk2u_pkg::UTF8_CONT | {2'b00, uni[5:0]};
          n    = 2'd2;
        end else begin
          b[0] = sk2u_pkg::BYTE_QUESTION;
          n    = 2'd0;
        end
      end else if (in_byte < sk2u_pkg::LEAD_LOW) begin
        b[0] = in_byte;
      end else if (in_byte >= sk2u_pkg::HALF_FIRST && in_byte <= sk2u_pkg::HALF_LAST) begin
        b[0] = sk2u_pkg::BYTE_UNDER;
      end else if (in_eos) begin
        b[0] = sk2u_pkg::BYTE_QUESTION;
      end else begin
        has_out          = 1'b0;
        lead_pending_nxt = 1'b1;
        lead_value_nxt   = in_byte;
      end
      // end of string appends the terminator
      if (in_eos) begin
        lead_pending_nxt = 1'b0;
        n                = n + 2'd1;
        b[n]             = sk2u_pkg::BYTE_ZERO;
      end
    end

    push_cmd.bytes    = b;
    push_cmd.last_idx = n;
    push_cmd.term     = (b[n] == sk2u_pkg::BYTE_ZERO) &&
                        (in_eos || in_byte == sk2u_pkg::BYTE_ZERO);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_pending_r <= 1'b0;
      lead_value_r   <= 8'h00;
      skipping_r     <= 1'b0;
    end else if (accept) begin
      lead_pending_r <= lead_pending_nxt;
      lead_value_r   <= lead_value_nxt;
      skipping_r     <= skipping_nxt;
    end
  end

endmodule

FILE: design/sk2u_queue.sv
// ----------------------------------------------------------------------------
// sk2u_queue: command queue
// Small first-in first-out store between classifier and serializer.
// ----------------------------------------------------------------------------
module sk2u_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sk2u_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output sk2u_pkg::cmd_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sk2u_pkg::cmd_t   entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_cmd;
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop) else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH)) else $error("queue count overflow");

endmodule

FILE: design/sk2u_back.sv
// ----------------------------------------------------------------------------
// sk2u_back: byte serializer
// Walks the head command one byte per cycle into the output register while the output register is free or being taken.
// ----------------------------------------------------------------------------
module sk2u_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  sk2u_pkg::cmd_t head,
  output logic           pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic           out_tlast,
  output logic           out_tuser
);

  logic [sk2u_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                       valid_r, valid_nxt;
  logic [7:0]                 byte_r;
  logic                       last_r;
  logic                       eot_r;
  logic                       load;
  logic                       at_end;

  assign load   = head_valid && (!valid_r || out_tready);
  assign at_end = (idx_r == head.last_idx);
  assign pop    = load && at_end;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = at_end ? '0 : idx_r + 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= head.bytes[idx_r];
      last_r <= at_end;
      eot_r  <= at_end && head.term;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = byte_r;
  assign out_tlast  = last_r;
  assign out_tuser  = eot_r;

  a_eot_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && eot_r |-> last_r) else $error("terminator not last of run");
  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !head_valid |-> idx_r == '0) else $error("byte index left over");
  a_idx_in_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> idx_r <= head.last_idx) else $error("byte index past command");

endmodule

FILE: sim/sjis_kana_to_utf8_stream_tb.sv
// ----------------------------------------------------------------------------
// sjis_kana_to_utf8_stream_tb: self-checking bench for the kana converter
// Drives Shift-JIS byte strings with random gaps, predicts the UTF-8 words and
// checks every output word in order while the sink stalls at random.
// ----------------------------------------------------------------------------
module sjis_kana_to_utf8_stream_tb;

  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned RANDOM_WORDS = 180;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       drain;  // hold this word back until all output has drained
  } sjis_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_text;
  } utf8_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       out_tuser;

  sjis_word_t sjis_bytes[$];
  utf8_word_t utf8_due[$];
  int unsigned errors = 0;

  // converter state as the predictor sees it
  logic       lead_held = 1'b0;
  logic [7:0] lead_byte = 8'h00;
  logic       skip_rest = 1'b0;

  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  bit          send_burst = 1'b0;
  bit          recv_burst = 1'b0;
  logic        presenting;
  logic        sent;
  sjis_word_t  next_word;
  utf8_word_t  want;
  int unsigned idle_cycles = 0;

  always #1 clk = ~clk;

  sjis_kana_to_utf8_stream dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // wait per word; now and then switch into or out of a run with no idling
  function automatic int unsigned draw_wait(inout bit burst);
    if ($urandom_range(0, 39) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic void push_utf8(logic [7:0] b, logic eot);
    utf8_word_t w;
    w.out_byte = b;
    w.last_of_run = 1'b0;
    w.end_of_text = eot;
    utf8_due = {utf8_due, w};
  endfunction

  function automatic void convert_byte(logic [7:0] c, logic eos);
    int unsigned n;
    logic [15:0] code;
    logic [15:0] cp;
    n = utf8_due.size();
    if (skip_rest) begin
      if (eos) skip_rest = 1'b0;
      return;
    end
    if (c == sk2u_pkg::BYTE_ZERO) begin
      if (lead_held) push_utf8(sk2u_pkg::BYTE_QUESTION, 1'b0);
      lead_held = 1'b0;
      push_utf8(sk2u_pkg::BYTE_ZERO, 1'b1);
      skip_rest = !eos;
    end else begin
      if (lead_held) begin
        code = {lead_byte, c};
        if (code >= sk2u_pkg::HIRA_FIRST && code <= sk2u_pkg::HIRA_LAST)
          cp = sk2u_pkg::HIRA_BASE + (code - sk2u_pkg::HIRA_FIRST);
        else if (code >= sk2u_pkg::KATA1_FIRST && code <= sk2u_pkg::KATA1_LAST)
          cp = sk2u_pkg::KATA1_BASE + (code - sk2u_pkg::KATA1_FIRST);
        else if (code >= sk2u_pkg::KATA2_FIRST && code <= sk2u_pkg::KATA2_LAST)
          cp = sk2u_pkg::KATA2_BASE + (code - sk2u_pkg::KATA2_FIRST);
        else cp = 16'h0000;
        if (cp == 16'h0000) begin
          push_utf8(sk2u_pkg::BYTE_QUESTION, 1'b0);
        end else begin
          push_utf8(sk2u_pkg::UTF8_LEAD3 | {4'h0, cp[15:12]}, 1'b0);
          push_utf8(sk2u_pkg::UTF8_CONT | {2'b00, cp[11:6]}, 1'b0);
          push_utf8(sk2u_pkg::UTF8_CONT | {2'b00, cp[5:0]}, 1'b0);
        end
        lead_held = 1'b0;
      end else if (c < sk2u_pkg::LEAD_LOW) begin
        push_utf8(c, 1'b0);
      end else if (c >= sk2u_pkg::HALF_FIRST && c <= sk2u_pkg::HALF_LAST) begin
        push_utf8(sk2u_pkg::BYTE_UNDER, 1'b0);
      end else if (eos) begin
        push_utf8(sk2u_pkg::BYTE_QUESTION, 1'b0);
      end else begin
        lead_held = 1'b1;
        lead_byte = c;
      end
      if (eos) begin
        lead_held = 1'b0;
        push_utf8(sk2u_pkg::BYTE_ZERO, 1'b1);
      end
    end
    if (utf8_due.size() > n) utf8_due[utf8_due.size()-1].last_of_run = 1'b1;
  endfunction

  task automatic add_byte(logic [7:0] data, logic last, logic drain);
    sjis_word_t w;
    w.data = data;
    w.last = last;
    w.drain = drain;
    sjis_bytes = {sjis_bytes, w};
  endtask

  function automatic logic [7:0] rand_lead();
    return $urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'h9F))
                                : 8'($urandom_range(8'hE0, 8'hFF));
  endfunction

  // source side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      sent = in_tvalid && in_tready;
      presenting = in_tvalid && !sent;
      if (sent) send_gap = draw_wait(send_burst);
      if (!presenting) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (sjis_bytes.size() > 0 &&
                     (!sjis_bytes[0].drain || (!sent && utf8_due.size() == 0))) begin
          next_word = sjis_bytes.pop_front();
          in_tdata <= next_word.data;
          in_tlast <= next_word.last;
          presenting = 1'b1;
        end
      end
      in_tvalid <= presenting;
    end
  end

  // sink side: check first, then predict the word taken on this edge
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (utf8_due.size() == 0) begin
          $error("unexpected output word %h last %b user %b", out_tdata, out_tlast, out_tuser);
          errors++;
        end else begin
          want = utf8_due.pop_front();
          if (out_tdata !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, out_tdata);
            errors++;
          end
          if (out_tlast !== want.last_of_run) begin
            $error("last_of_run: expected %b, got %b", want.last_of_run, out_tlast);
            errors++;
          end
          if (out_tuser !== want.end_of_text) begin
            $error("end_of_text: expected %b, got %b", want.end_of_text, out_tuser);
            errors++;
          end
        end
        recv_stall = draw_wait(recv_burst);
      end
      if (in_tvalid && in_tready) convert_byte(in_tdata, in_tlast);
      if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int unsigned counted;
    int unsigned n_chars;
    int unsigned ending;
    int unsigned kind;
    logic [15:0] code;
    logic        drain_first;

    // directed: pass-through limits, half-width, range edges, misses, ends
    add_byte(8'h41, 1'b0, 1'b0);
    add_byte(8'h01, 1'b0, 1'b0);
    add_byte(8'h7F, 1'b0, 1'b0);
    add_byte(8'hA0, 1'b0, 1'b0);
    add_byte(8'hDF, 1'b0, 1'b0);
    add_byte(8'h82, 1'b0, 1'b0);  add_byte(8'h9F, 1'b0, 1'b0);
    add_byte(8'h82, 1'b0, 1'b0);  add_byte(8'hF1, 1'b0, 1'b0);
    add_byte(8'h83, 1'b0, 1'b0);  add_byte(8'h7E, 1'b0, 1'b0);
    add_byte(8'h83, 1'b0, 1'b0);  add_byte(8'h96, 1'b0, 1'b0);
    // gap between the two katakana ranges, and an odd lead
    add_byte(8'h83, 1'b0, 1'b0);  add_byte(8'h7F, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0);  add_byte(8'hFF, 1'b0, 1'b0);
    // lead cut off by a zero, then skipped words until end of string
    add_byte(8'h80, 1'b0, 1'b0);  add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'h41, 1'b0, 1'b0);  add_byte(8'h12, 1'b1, 1'b0);
    // lone lead at the end, empty string, pairs ending the string
    add_byte(8'hE0, 1'b1, 1'b1);
    add_byte(8'h00, 1'b1, 1'b0);
    add_byte(8'h9F, 1'b0, 1'b0);  add_byte(8'h41, 1'b1, 1'b0);
    add_byte(8'h83, 1'b0, 1'b1);  add_byte(8'h80, 1'b1, 1'b0);

    // random strings, mostly well formed, some noise
    counted = 0;
    while (counted < RANDOM_WORDS) begin
      if ($urandom_range(0, 9) == 0) begin
        add_byte(8'($urandom), 1'($urandom), 1'b0);
        counted++;
      end else begin
        n_chars = $urandom_range(0, 10);
        ending = $urandom_range(0, 9);
        drain_first = ($urandom_range(0, 24) == 0);
        for (int i = 0; i < n_chars; i++) begin
          kind = $urandom_range(0, 9);
          if (kind <= 2) begin
            add_byte(8'($urandom_range(1, 8'h7F)), 1'b0, drain_first);
            counted++;
          end else if (kind == 3) begin
            add_byte(8'($urandom_range(sk2u_pkg::HALF_FIRST, sk2u_pkg::HALF_LAST)),
                     1'b0, drain_first);
            counted++;
          end else if (kind <= 8) begin
            case ($urandom_range(0, 2))
              0: code = sk2u_pkg::HIRA_FIRST +
                        16'($urandom_range(0, sk2u_pkg::HIRA_LAST - sk2u_pkg::HIRA_FIRST));
              1: code = sk2u_pkg::KATA1_FIRST +
                        16'($urandom_range(0, sk2u_pkg::KATA1_LAST - sk2u_pkg::KATA1_FIRST));
              default: code = sk2u_pkg::KATA2_FIRST +
                        16'($urandom_range(0, sk2u_pkg::KATA2_LAST - sk2u_pkg::KATA2_FIRST));
            endcase
            add_byte(code[15:8], 1'b0, drain_first);
            add_byte(code[7:0], 1'b0, 1'b0);
            counted += 2;
          end else begin
            add_byte(rand_lead(), 1'b0, drain_first);
            add_byte(8'($urandom_range(1, 255)), 1'b0, 1'b0);
            counted += 2;
          end
          drain_first = 1'b0;
        end
        // a lead with no second byte before the end or the zero
        if (ending == 3 || ending == 8) begin
          add_byte(rand_lead(), 1'b0, drain_first);
          counted++;
        end
        if (ending <= 3 && sjis_bytes.size() > 0 && (n_chars > 0 || ending == 3)) begin
          sjis_bytes[sjis_bytes.size()-1].last = 1'b1;
        end else if (ending <= 6) begin
          add_byte(sk2u_pkg::BYTE_ZERO, 1'b1, 1'b0);
          counted++;
        end else begin
          add_byte(sk2u_pkg::BYTE_ZERO, 1'b0, 1'b0);
          counted++;
          // bytes after the zero are ignored up to the end of string
          repeat ($urandom_range(0, 3)) add_byte(8'($urandom), 1'b0, 1'b0);
          add_byte(8'($urandom), 1'b1, 1'b0);
        end
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (sjis_bytes.size() > 0 || in_tvalid || utf8_due.size() > 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (utf8_due.size() > 0) begin
      $error("%0d output words never arrived", utf8_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
